// ===== hw/rtl/icdf_pkg.sv =====
// ----------------------------------------------------------------------------
// icdf_pkg
// shared widths, codes and state type of the inverse cdf table sampler
// ----------------------------------------------------------------------------
package icdf_pkg;

  // payload widths
  localparam int CmdW      = 1;
  localparam int IndexW    = 10;
  localparam int ValueW    = 17;
  localparam int FracW     = 16;
  localparam int RadiusW   = 26;
  localparam int StatusW   = 2;
  localparam int BinWidthW = 16;

  // defaults and limits
  localparam int unsigned TableBinsDflt = 1024;
  localparam logic [BinWidthW-1:0] BinWidthRst = 16'd256;
  localparam logic [FracW-1:0]     FracMax     = 16'hFFFF;
  localparam longint unsigned      RadiusMax   = 64'd67108863;

  // command codes
  localparam logic [CmdW-1:0] CmdLoad  = 1'b0;
  localparam logic [CmdW-1:0] CmdQuery = 1'b1;

  // status codes
  localparam logic [StatusW-1:0] StatusOk   = 2'd0;
  localparam logic [StatusW-1:0] StatusLoad = 2'd1;
  localparam logic [StatusW-1:0] StatusFlat = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StLower,
    StUpper,
    StDiv,
    StMul,
    StFinish
  } state_e;

endpackage

// ===== hw/rtl/inverse_cdf_table_sampler_core.sv =====
// ----------------------------------------------------------------------------
// inverse_cdf_table_sampler_core
// inverse transform sampler over a loaded cumulative distribution table
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item per transfer.
//   cmd_i = load writes entry_value_i at entry_index_i (ignored when the
//   index is beyond the table) and returns a result with status = load.
//   cmd_i = query binary-searches the table for query_value_i, interpolates
//   within the bin and returns sample_radius, bin_found, bin_fraction.
//   Output channel (out_valid_o / out_ready_i) holds each result in a
//   register until taken; the next item is accepted meanwhile, and the
//   sequencer waits in its final state only if that register is still full.
//   cfg_we_i writes bin_width from cfg_wdata_i in the same cycle.
//   Sequencing: one item at a time through a single-port table memory with a
//   registered read. A load goes straight from its write to the final state;
//   a query makes about log2(TableBins) search reads and 2 bound reads, then
//   runs the serial divider only when the value falls inside a rising bin.
//   The search reads and the serial divider set how long a query takes.
//   Reset: bin_width returns to 256, the table is undefined until loaded.
// ----------------------------------------------------------------------------
module inverse_cdf_table_sampler_core #(
  parameter int unsigned TableBins = icdf_pkg::TableBinsDflt
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [icdf_pkg::BinWidthW-1:0] cfg_wdata_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [icdf_pkg::CmdW-1:0]      cmd_i,
  input  logic [icdf_pkg::IndexW-1:0]    entry_index_i,
  input  logic [icdf_pkg::ValueW-1:0]    entry_value_i,
  input  logic [icdf_pkg::ValueW-1:0]    query_value_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [icdf_pkg::RadiusW-1:0]   sample_radius_o,
  output logic [icdf_pkg::IndexW-1:0]    bin_found_o,
  output logic [icdf_pkg::FracW-1:0]     bin_fraction_o,
  output logic [icdf_pkg::StatusW-1:0]   status_o
);

  localparam int AW      = $clog2(TableBins);
  localparam int ValueW  = icdf_pkg::ValueW;
  localparam int FracW   = icdf_pkg::FracW;
  localparam int IndexW  = icdf_pkg::IndexW;
  localparam int RadiusW = icdf_pkg::RadiusW;
  localparam int StatusW = icdf_pkg::StatusW;
  localparam int BwW     = icdf_pkg::BinWidthW;
  localparam int MulW    = AW + FracW + BwW;
  localparam int LoExtW  = (AW > IndexW) ? AW : IndexW;
  localparam logic [AW-1:0] HiInit  = AW'(TableBins - 1);
  localparam logic [AW-1:0] MidInit = AW'((TableBins - 1) / 2);

  icdf_pkg::state_e state_q, state_d;

  logic [BwW-1:0]     bw_q;
  logic [AW-1:0]      lo_q, hi_q, mid_q;
  logic [AW-1:0]      lo_d, hi_d, mid_d;
  logic [ValueW-1:0]  qv_q, x1_q;
  logic [FracW-1:0]   frac_q;
  logic [StatusW-1:0] status_q;
  logic [MulW-1:0]    prod_q;
  logic               search_more;

  logic               out_valid_q;
  logic [RadiusW-1:0] out_radius_q;
  logic [IndexW-1:0]  out_bin_q;
  logic [FracW-1:0]   out_frac_q;
  logic [StatusW-1:0] out_status_q;

  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [ValueW-1:0]  mem_rdata;
  logic               div_start;
  logic               div_done;
  logic [FracW-1:0]   div_quot;

  logic               in_xfer;
  logic               push;
  logic               idx_ok;
  logic [MulW-FracW-1:0] rad_full;
  logic [RadiusW-1:0] rad_sat;
  logic [LoExtW-1:0]  lo_ext;

  assign in_xfer = in_valid_i && in_ready_o;
  assign idx_ok  = (32'(entry_index_i) < 32'(TableBins));

  // table memory
  icdf_mem #(
    .Depth (TableBins),
    .AddrW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (entry_value_i),
    .rdata_o (mem_rdata)
  );

  // fraction divider
  icdf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (qv_q - x1_q),
    .den_i   (mem_rdata - x1_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // search step: narrow the bracket with the word read at mid
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (mem_rdata < qv_q) begin
      lo_d = mid_q;
    end else begin
      hi_d = mid_q;
    end
    mid_d       = AW'(((AW + 1)'(lo_d) + (AW + 1)'(hi_d)) >> 1);
    search_more = ((hi_d - lo_d) > AW'(1));
  end

  // sequencer: next state, memory port and divider start
  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_addr  = MidInit;
    div_start = 1'b0;
    unique case (state_q)
      icdf_pkg::StIdle: begin
        if (in_xfer) begin
          if (cmd_i == icdf_pkg::CmdLoad) begin
            mem_we   = idx_ok;
            mem_addr = AW'(entry_index_i);
            state_d  = icdf_pkg::StFinish;
          end else begin
            state_d = icdf_pkg::StSearch;
          end
        end
      end
      icdf_pkg::StSearch: begin
        if (search_more) begin
          mem_addr = mid_d;
        end else begin
          mem_addr = lo_d;
          state_d  = icdf_pkg::StLower;
        end
      end
      icdf_pkg::StLower: begin
        mem_addr = lo_q + AW'(1);
        state_d  = icdf_pkg::StUpper;
      end
      icdf_pkg::StUpper: begin
        priority if (mem_rdata <= x1_q || qv_q <= x1_q || qv_q >= mem_rdata) begin
          state_d = icdf_pkg::StMul;
        end else begin
          div_start = 1'b1;
          state_d   = icdf_pkg::StDiv;
        end
      end
      icdf_pkg::StDiv: begin
        if (div_done) begin
          state_d = icdf_pkg::StMul;
        end
      end
      icdf_pkg::StMul: begin
        state_d = icdf_pkg::StFinish;
      end
      icdf_pkg::StFinish: begin
        if (push) begin
          state_d = icdf_pkg::StIdle;
        end
      end
      default: state_d = icdf_pkg::StIdle;
    endcase
  end

  // state register and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= icdf_pkg::StIdle;
      bw_q    <= icdf_pkg::BinWidthRst;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        bw_q <= cfg_wdata_i;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      icdf_pkg::StIdle: begin
        qv_q     <= query_value_i;
        lo_q     <= '0;
        hi_q     <= HiInit;
        mid_q    <= MidInit;
        frac_q   <= '0;
        prod_q   <= '0;
        status_q <= (cmd_i == icdf_pkg::CmdLoad) ? icdf_pkg::StatusLoad : icdf_pkg::StatusOk;
      end
      icdf_pkg::StSearch: begin
        lo_q  <= lo_d;
        hi_q  <= hi_d;
        mid_q <= mid_d;
      end
      icdf_pkg::StLower: begin
        x1_q <= mem_rdata;
      end
      icdf_pkg::StUpper: begin
        priority if (mem_rdata <= x1_q) begin
          status_q <= icdf_pkg::StatusFlat;
        end else if (qv_q <= x1_q) begin
          frac_q <= '0;
        end else if (qv_q >= mem_rdata) begin
          frac_q <= icdf_pkg::FracMax;
        end else begin
          frac_q <= '0;
        end
      end
      icdf_pkg::StDiv: begin
        if (div_done) begin
          frac_q <= div_quot;
        end
      end
      icdf_pkg::StMul: begin
        prod_q <= MulW'({lo_q, frac_q}) * MulW'(bw_q);
      end
      icdf_pkg::StFinish: begin
      end
      default: begin
      end
    endcase
  end

  // result: drop the fraction bits and saturate
  assign rad_full = prod_q[MulW-1:FracW];
  assign rad_sat  = (64'(rad_full) > 64'(icdf_pkg::RadiusMax)) ?
                    RadiusW'(icdf_pkg::RadiusMax) : RadiusW'(rad_full);
  assign lo_ext   = LoExtW'(lo_q);

  // output register, filled when empty or being drained
  assign push = (state_q == icdf_pkg::StFinish) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_radius_q <= rad_sat;
      out_bin_q    <= lo_ext[IndexW-1:0];
      out_frac_q   <= frac_q;
      out_status_q <= status_q;
    end
  end

  assign in_ready_o      = (state_q == icdf_pkg::StIdle);
  assign out_valid_o     = out_valid_q;
  assign sample_radius_o = out_radius_q;
  assign bin_found_o     = out_bin_q;
  assign bin_fraction_o  = out_frac_q;
  assign status_o        = out_status_q;

endmodule

// ===== hw/rtl/icdf_mem.sv =====
// ----------------------------------------------------------------------------
// icdf_mem
// single-port table memory, registered read
// ----------------------------------------------------------------------------
module icdf_mem #(
  parameter int unsigned Depth = icdf_pkg::TableBinsDflt,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           addr_i,
  input  logic [icdf_pkg::ValueW-1:0] wdata_i,
  output logic [icdf_pkg::ValueW-1:0] rdata_o
);

  logic [icdf_pkg::ValueW-1:0] mem_q [Depth];
  logic [icdf_pkg::ValueW-1:0] rdata_q;

  // write and read one word per cycle at the shared address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/icdf_div.sv =====
// ----------------------------------------------------------------------------
// icdf_div
// restoring divider for the in-bin fraction, one quotient bit per cycle
// ----------------------------------------------------------------------------
module icdf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [icdf_pkg::ValueW-1:0] num_i,
  input  logic [icdf_pkg::ValueW-1:0] den_i,
  output logic                        done_o,
  output logic [icdf_pkg::FracW-1:0]  quot_o
);

  localparam int ValueW = icdf_pkg::ValueW;
  localparam int FracW  = icdf_pkg::FracW;
  localparam int CntW   = $clog2(FracW);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [ValueW:0]   rem_q;
  logic [ValueW-1:0] den_q;
  logic [FracW-1:0]  quot_q;
  logic [ValueW:0]   rem_sh;
  logic [ValueW:0]   rem_diff;
  logic              q_bit;

  // shift and trial subtract; remainder stays below the divisor
  assign rem_sh   = {rem_q[ValueW-1:0], 1'b0};
  assign rem_diff = rem_sh - {1'b0, den_q};
  assign q_bit    = (rem_sh >= {1'b0, den_q});

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(FracW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= q_bit ? rem_diff : rem_sh;
      quot_q <= {quot_q[FracW-2:0], q_bit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
